// ----- rtl/core/fantc_pkg.sv -----
// Package for the fan thermostat core: shared types, event codes and constants.
// No dependencies; every other file of the core imports it.

package fantc_pkg;

	// Event codes carried on the op field.
	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_TX_START  = 2'd1,
		OP_TX_END    = 2'd2,
		OP_POWER_OFF = 2'd3
	} fantc_op_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_FAN_MODE  = 2'd0,
		REG_LOW_THR   = 2'd1,
		REG_HIGH_THR  = 2'd2,
		REG_COOLDOWN  = 2'd3
	} fantc_reg_t;

	// Fan mode codes; the unused code behaves as auto.
	localparam logic [1:0] MODE_AUTO = 2'd0;
	localparam logic [1:0] MODE_OFF  = 2'd1;
	localparam logic [1:0] MODE_ON   = 2'd2;

	localparam int TEMP_W = 13;
	localparam int SECS_W = 7;

	// Valid sensor window in 1/16 degree steps (-20 and 120 degrees).
	localparam logic signed [TEMP_W-1:0] TEMP_MIN_Q4 = -13'sd320;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX_Q4 = 13'sd1920;

	// Cooldown conversion: ceiling of ms / 1000, clamped at 66 seconds.
	localparam logic [31:0]       CLAMP_MS    = 32'd65000;
	localparam logic [SECS_W-1:0] CLAMP_SECS  = 7'd66;
	localparam logic [16:0]       ROUND_UP_MS = 17'd999;
	// 2^26 / 1000 rounded up; exact quotient for dividends below 66000.
	localparam logic [16:0]       RECIP_1000  = 17'd67109;
	localparam int                RECIP_SHIFT = 26;

	// Reset values of the registers.
	localparam logic [1:0]  RST_FAN_MODE = MODE_AUTO;
	localparam logic [6:0]  RST_LOW_THR  = 7'd30;
	localparam logic [6:0]  RST_HIGH_THR = 7'd36;
	localparam logic [15:0] RST_COOLDOWN = 16'd10000;

	typedef struct packed {
		logic [1:0]  fan_mode;
		logic [6:0]  low_threshold_c;
		logic [6:0]  high_threshold_c;
		logic [15:0] cooldown_ms;
	} fantc_cfg_t;

	typedef struct packed {
		logic        thermostat_latch;
		logic        transmitting;
		logic        cooldown_pending;
		logic [31:0] cooldown_deadline;
		logic        halted;
		logic        fan_level;
		logic        fault_flag;
	} fantc_state_t;

endpackage

// ----- rtl/core/fantc_cfg.sv -----
// Configuration register bank of the fan thermostat core.
// Depends on fantc_pkg for the register indexes and the configuration struct.

module fantc_cfg import fantc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output fantc_cfg_t  cfg
);

	fantc_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fan_mode         <= RST_FAN_MODE;
			cfg_q.low_threshold_c  <= RST_LOW_THR;
			cfg_q.high_threshold_c <= RST_HIGH_THR;
			cfg_q.cooldown_ms      <= RST_COOLDOWN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (fantc_reg_t'(cfg_index))
				REG_FAN_MODE: cfg_q.fan_mode         <= cfg_data[1:0];
				REG_LOW_THR:  cfg_q.low_threshold_c  <= cfg_data[6:0];
				REG_HIGH_THR: cfg_q.high_threshold_c <= cfg_data[6:0];
				REG_COOLDOWN: cfg_q.cooldown_ms      <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/fantc_secs.sv -----
// Cooldown seconds: ceiling of a millisecond count divided by 1000, clamped at 66.
// Depends on fantc_pkg for the reciprocal and clamp constants.

module fantc_secs import fantc_pkg::*; (
	input  logic              active,
	input  logic [31:0]       ms,
	output logic [SECS_W-1:0] secs
);

	logic [16:0] dividend;
	logic [33:0] prod;
	logic        clamp;

	// Below the clamp the count fits in 16 bits, so the rounded dividend fits in 17.
	assign clamp    = ms > CLAMP_MS;
	assign dividend = ms[16:0] + ROUND_UP_MS;
	assign prod     = 34'(dividend) * 34'(RECIP_1000);

	always_comb begin
		if (!active) begin
			secs = '0;
		end else if (clamp) begin
			secs = CLAMP_SECS;
		end else begin
			secs = prod[RECIP_SHIFT +: SECS_W];
		end
	end

endmodule

// ----- rtl/core/fantc_step.sv -----
// Next-state and result logic for one event of the fan thermostat core.
// Depends on fantc_pkg and instantiates fantc_secs for the cooldown report.

module fantc_step import fantc_pkg::*; (
	input  fantc_state_t             st,
	input  fantc_cfg_t               cfg,
	input  logic [1:0]               op,
	input  logic [31:0]              now_ms,
	input  logic signed [TEMP_W-1:0] temperature,
	input  logic                     temp_valid,
	output fantc_state_t             nx,
	output logic [SECS_W-1:0]        secs
);

	logic [31:0]       since_dl;
	logic [31:0]       remain;
	logic              reached;
	logic              fault;
	logic signed [13:0] temp_x;
	logic signed [13:0] hi_q4;
	logic signed [13:0] lo_q4;
	logic              cooling;
	logic              arm;
	logic [31:0]       remain_n;
	logic              reached_n;
	logic              pend_n;
	logic [31:0]       report_ms;
	logic              report_on;

	// Deadline reached when the wrapped difference now - deadline is not negative.
	assign since_dl = now_ms - st.cooldown_deadline;
	assign remain   = st.cooldown_deadline - now_ms;
	assign reached  = ~since_dl[31];

	assign fault = !temp_valid || (temperature < TEMP_MIN_Q4) || (temperature > TEMP_MAX_Q4);

	assign temp_x = 14'(temperature);
	assign hi_q4  = signed'({3'b000, cfg.high_threshold_c, 4'b0000});
	assign lo_q4  = signed'({3'b000, cfg.low_threshold_c, 4'b0000});

	assign cooling = st.transmitting || (st.cooldown_pending && !reached);

	always_comb begin
		nx  = st;
		arm = 1'b0;
		unique case (fantc_op_t'(op))
			OP_TICK: begin
				if (!st.halted) begin
					nx.fault_flag = fault;
					if (cfg.fan_mode == MODE_ON) begin
						nx.fan_level = 1'b1;
					end else if (cfg.fan_mode == MODE_OFF) begin
						nx.fan_level = 1'b0;
					end else if (fault) begin
						nx.fan_level = 1'b1;
					end else begin
						if (temp_x >= hi_q4) begin
							nx.thermostat_latch = 1'b1;
						end else if (temp_x < lo_q4) begin
							nx.thermostat_latch = 1'b0;
						end
						nx.fan_level = nx.thermostat_latch || cooling;
					end
				end
			end
			OP_TX_START: begin
				nx.transmitting = 1'b1;
				if (cfg.fan_mode != MODE_OFF && cfg.fan_mode != MODE_ON && !st.halted) begin
					nx.fan_level = 1'b1;
				end
			end
			OP_TX_END: begin
				if (!st.halted) begin
					arm                  = 1'b1;
					nx.cooldown_deadline = now_ms + 32'(cfg.cooldown_ms);
					nx.cooldown_pending  = 1'b1;
				end
				nx.transmitting = 1'b0;
			end
			OP_POWER_OFF: begin
				nx.halted           = 1'b1;
				nx.transmitting     = 1'b0;
				nx.cooldown_pending = 1'b0;
				nx.fan_level        = 1'b0;
			end
			default: ;
		endcase

		// A freshly armed deadline lies exactly cooldown_ms ahead.
		if (arm) begin
			remain_n  = 32'(cfg.cooldown_ms);
			reached_n = (cfg.cooldown_ms == '0);
		end else begin
			remain_n  = remain;
			reached_n = reached;
		end

		// The report retires an expired deadline unless a transmit is active.
		pend_n              = nx.cooldown_pending && (nx.transmitting || !reached_n);
		nx.cooldown_pending = pend_n;

		if (nx.transmitting) begin
			report_ms = 32'(cfg.cooldown_ms);
			report_on = 1'b1;
		end else begin
			report_ms = remain_n;
			report_on = pend_n;
		end
	end

	fantc_secs u_secs (
		.active (report_on),
		.ms     (report_ms),
		.secs   (secs)
	);

endmodule

// ----- rtl/core/fan_thermostat_with_tx_cooldown_core.sv -----
// Fan thermostat core: one request in, one result out, both with valid and stall.
// A request accepted into the input stage has its result registered in the result register.
// Throughput: one request per cycle unless out_stall holds a result; the event logic sits
// between the input stage and the result register, and state is written back in the same cycle.
// Reset (arst_n, asynchronous, active low) clears control state, loads the register
// defaults and sets the fan on. Depends on fantc_pkg, fantc_cfg, fantc_step, fantc_secs.

module fan_thermostat_with_tx_cooldown_core import fantc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// Request channel.
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               op,
	input  logic [31:0]              now_ms,
	input  logic signed [TEMP_W-1:0] temperature,
	input  logic                     temp_valid,
	// Result channel.
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     fan_drive,
	output logic                     thermostat_on,
	output logic [SECS_W-1:0]        cooldown_secs,
	output logic                     sensor_fault,
	// Configuration write channel.
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [15:0]              cfg_data
);

	fantc_cfg_t   cfg;
	fantc_state_t st_q;
	fantc_state_t st_nx;
	logic [SECS_W-1:0] secs_nx;

	// Input stage.
	logic                     valid_s1;
	logic [1:0]               op_s1;
	logic [31:0]              now_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic                     tvalid_s1;

	// Result register.
	logic              out_valid_q;
	logic              fan_q;
	logic              latch_q;
	logic [SECS_W-1:0] secs_q;
	logic              fault_q;

	logic advance;

	// The result register takes a new result whenever it is empty or being drained,
	// so the input stage only stalls when a finished result is held back.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	fantc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fantc_step u_step (
		.st          (st_q),
		.cfg         (cfg),
		.op          (op_s1),
		.now_ms      (now_s1),
		.temperature (temp_s1),
		.temp_valid  (tvalid_s1),
		.nx          (st_nx),
		.secs        (secs_nx)
	);

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1     <= op;
			now_s1    <= now_ms;
			temp_s1   <= temperature;
			tvalid_s1 <= temp_valid;
		end
	end

	// Controller state is committed as the event moves into the result register,
	// so the request right behind it sees the updated state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.thermostat_latch  <= 1'b0;
			st_q.transmitting      <= 1'b0;
			st_q.cooldown_pending  <= 1'b0;
			st_q.cooldown_deadline <= '0;
			st_q.halted            <= 1'b0;
			st_q.fan_level         <= 1'b1;
			st_q.fault_flag        <= 1'b0;
		end else if (valid_s1 && advance) begin
			st_q <= st_nx;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			fan_q   <= st_nx.fan_level;
			latch_q <= st_nx.thermostat_latch;
			secs_q  <= secs_nx;
			fault_q <= st_nx.fault_flag;
		end
	end

	assign out_valid     = out_valid_q;
	assign fan_drive     = fan_q;
	assign thermostat_on = latch_q;
	assign cooldown_secs = secs_q;
	assign sensor_fault  = fault_q;

	// After power off the fan is held off and no cooldown can be armed.
	a_halt_fan_off: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted |-> !st_q.fan_level)
		else $error("fan on while halted");

	a_halt_no_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted |-> !st_q.cooldown_pending)
		else $error("cooldown pending while halted");

	a_secs_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (secs_q <= CLAMP_SECS))
		else $error("cooldown seconds above clamp");

	a_accept_loads_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted request not held in input stage");

endmodule
